// ===== hw/rtl/spa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// shared types and constants of the segregated pool allocator
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int ADDR_W     = 20;
  localparam int SIZE_W     = 16;
  localparam int UNIT_W     = 15;
  localparam int LINK_W     = 16;
  localparam int CLS_W      = 3;
  localparam int CHUNK_W    = 9;
  localparam int OFF_W      = 7;
  localparam int NEED_W     = 17;
  localparam int NUM_CLASSES = 8;
  localparam int MAX_CHUNKS = 256;
  localparam int CHUNK_BYTES = 4096;
  localparam int UNITS_PER_CHUNK = CHUNK_BYTES / 32;

  localparam logic [SIZE_W-1:0] POOL_LIMIT   = SIZE_W'(4088);
  localparam logic [NEED_W-1:0] HEADER_BYTES = NEED_W'(8);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_BIG  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic cap;
    logic set_err;
    logic rd_link;
    logic pop_wb;
    logic carve_start;
    logic carve_step;
    logic rd_class;
    logic free_wb;
    logic out_load;
  } spa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_bad;
    logic head_valid;
    logic heap_full;
    logic free_hit;
    logic carve_last;
    logic out_free;
  } spa_sts_t;

  // smallest class whose block holds need bytes, capped at the largest class
  function automatic logic [CLS_W-1:0] class_of(input logic [NEED_W-1:0] need);
    logic [CLS_W-1:0] c;
    c = CLS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
      if ((NEED_W'(32) << i) >= need) begin
        c = CLS_W'(i);
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/spa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/spa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_ctrl
// request sequencer: decode, pop, carve, free and result hand-off
// ----------------------------------------------------------------------------
module spa_ctrl
  import spa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spa_sts_t sts_i,
  output spa_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_POPRD  = 7'b0000100,
    S_POPWB  = 7'b0001000,
    S_CARVE  = 7'b0010000,
    S_FREE   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_free) begin
          if (sts_i.free_hit) begin
            cmd_o.rd_class = 1'b1;
            state_d        = S_FREE;
          end else begin
            state_d = S_DONE;
          end
        end else if (sts_i.size_bad) begin
          cmd_o.set_err = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.head_valid) begin
          state_d = S_POPRD;
        end else if (sts_i.heap_full) begin
          cmd_o.set_err = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.carve_start = 1'b1;
          state_d           = S_CARVE;
        end
      end
      S_CARVE: begin
        cmd_o.carve_step = 1'b1;
        if (sts_i.carve_last) begin
          state_d = S_POPRD;
        end
      end
      S_POPRD: begin
        cmd_o.rd_link = 1'b1;
        state_d       = S_POPWB;
      end
      S_POPWB: begin
        cmd_o.pop_wb = 1'b1;
        state_d      = S_DONE;
      end
      S_FREE: begin
        cmd_o.free_wb = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/spa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_datapath
// list heads, chunk counter, link and chunk class memories, result register
// ----------------------------------------------------------------------------
module spa_datapath
  import spa_pkg::*;
#(
  parameter int CHUNK_LIM = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spa_cmd_t          cmd_i,
  output spa_sts_t          sts_o,
  input  logic              in_kind_i,
  input  logic [SIZE_W-1:0] in_size_i,
  input  logic [ADDR_W-1:0] in_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic [1:0]        out_status_o
);

  localparam int LINK_DEPTH = CHUNK_LIM * UNITS_PER_CHUNK;
  localparam int LAW = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam int CAW = (CHUNK_LIM > 1) ? $clog2(CHUNK_LIM) : 1;
  localparam logic [CHUNK_W-1:0] LIM = CHUNK_W'(CHUNK_LIM);

  logic              kind_q;
  logic              zero_q, big_q, null_q;
  logic [CLS_W-1:0]  cls_q;
  logic [UNIT_W-1:0] unit_q;
  logic [LINK_W-1:0] heads_q [NUM_CLASSES];
  logic [LINK_W-1:0] heads_d [NUM_CLASSES];
  logic [CHUNK_W-1:0] chunks_q, chunks_d;
  logic [OFF_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [1:0]        res_sts_q, res_sts_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q;
  logic [1:0]        out_sts_q;

  logic [ADDR_W-1:0] blk_addr;
  logic [LINK_W-1:0] head_cur;
  logic [OFF_W-1:0]  off;
  logic [OFF_W:0]    next_off;
  logic [UNIT_W-1:0] carve_unit;
  logic [LINK_W-1:0] carve_link;
  logic [UNIT_W-1:0] free_unit;
  logic [CLS_W-1:0]  free_cls;

  logic              link_we;
  logic [LAW-1:0]    link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [LINK_W-1:0] link_rdata;
  logic [CLS_W-1:0]  cls_rdata;

  assign blk_addr   = in_addr_i - ADDR_W'(HEADER_BYTES);
  assign head_cur   = heads_q[cls_q];
  assign off        = cnt_q << cls_q;
  assign next_off   = {1'b0, off} + ((OFF_W + 1)'(1) << cls_q);
  assign carve_unit = {chunks_q[7:0], off};
  assign carve_link = next_off[OFF_W] ? '0 : {1'b1, chunks_q[7:0], next_off[OFF_W-1:0]};
  assign free_cls   = cls_rdata;
  assign free_unit  = unit_q & (UNIT_W'(15'h7fff) << free_cls);

  assign sts_o.is_free    = kind_q;
  assign sts_o.size_bad   = zero_q | big_q;
  assign sts_o.head_valid = head_cur[LINK_W-1];
  assign sts_o.heap_full  = (chunks_q >= LIM);
  assign sts_o.free_hit   = !null_q && ({1'b0, unit_q[UNIT_W-1:OFF_W]} < chunks_q);
  assign sts_o.carve_last = next_off[OFF_W];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    link_we    = cmd_i.carve_step | cmd_i.free_wb;
    link_waddr = cmd_i.free_wb ? free_unit[LAW-1:0] : carve_unit[LAW-1:0];
    link_wdata = cmd_i.free_wb ? heads_q[free_cls] : carve_link;
  end

  spa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (cmd_i.rd_link),
    .raddr_i (head_cur[LAW-1:0]),
    .rdata_o (link_rdata)
  );

  spa_ram #(
    .WIDTH (CLS_W),
    .DEPTH (CHUNK_LIM)
  ) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.carve_start),
    .waddr_i (chunks_q[CAW-1:0]),
    .wdata_i (cls_q),
    .re_i    (cmd_i.rd_class),
    .raddr_i (unit_q[CAW+OFF_W-1:OFF_W]),
    .rdata_o (cls_rdata)
  );

  always_comb begin
    heads_d     = heads_q;
    chunks_d    = chunks_q;
    cnt_d       = cnt_q;
    res_addr_d  = res_addr_q;
    res_sts_d   = res_sts_q;
    out_valid_d = out_valid_q;
    if (cmd_i.cap) begin
      res_addr_d = '0;
      res_sts_d  = ST_OK;
    end
    if (cmd_i.set_err) begin
      res_addr_d = '0;
      res_sts_d  = zero_q ? ST_ZERO : (big_q ? ST_BIG : ST_FULL);
    end
    if (cmd_i.carve_start) begin
      cnt_d = '0;
    end
    if (cmd_i.carve_step) begin
      cnt_d = cnt_q + OFF_W'(1);
      if (next_off[OFF_W]) begin
        heads_d[cls_q] = {1'b1, chunks_q[7:0], {OFF_W{1'b0}}};
        chunks_d       = chunks_q + CHUNK_W'(1);
      end
    end
    if (cmd_i.pop_wb) begin
      heads_d[cls_q] = link_rdata;
      res_addr_d     = {head_cur[UNIT_W-1:0], 5'b01000};
    end
    if (cmd_i.free_wb) begin
      heads_d[free_cls] = {1'b1, free_unit};
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_q[i] <= '0;
      end
      chunks_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      heads_q     <= heads_d;
      chunks_q    <= chunks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    res_addr_q <= res_addr_d;
    res_sts_q  <= res_sts_d;
    if (cmd_i.cap) begin
      kind_q <= in_kind_i;
      zero_q <= (in_size_i == '0);
      big_q  <= (in_size_i > POOL_LIMIT);
      cls_q  <= class_of(NEED_W'(in_size_i) + HEADER_BYTES);
      null_q <= (in_addr_i == '0);
      unit_q <= blk_addr[ADDR_W-1:5];
    end
    if (cmd_i.out_load) begin
      out_addr_q <= res_addr_q;
      out_sts_q  <= res_sts_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_sts_q;

endmodule

// ===== hw/rtl/segregated_pool_allocator.sv =====
`timescale 1ns / 1ps
// after accept an allocate from a non-empty list goes decode, link read, head write-back,
// done; a free in the heap goes decode, list write, done; any other free, a size error or
// a full heap goes decode, done; an allocate from an empty list carves a chunk first, one
// link write per cycle; one transaction at a time, next accept in the cycle after result load
// reset: list heads and chunk count clear at once; the memories are not
// cleared and need no clearing pass
// ----------------------------------------------------------------------------
// segregated_pool_allocator
// power-of-two size class allocator with lifo free lists over a chunked heap
// ----------------------------------------------------------------------------
module segregated_pool_allocator
  import spa_pkg::*;
#(
  parameter int HEAP_CHUNKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // request_size[15:0], payload_address[35:16], zero
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // result_address[19:0], status[21:20], zero
);

  localparam int CHUNK_LIM = (HEAP_CHUNKS < MAX_CHUNKS) ? HEAP_CHUNKS : MAX_CHUNKS;

  spa_cmd_t          cmd;
  spa_sts_t          sts;
  logic [ADDR_W-1:0] res_addr;
  logic [1:0]        res_status;

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spa_datapath #(
    .CHUNK_LIM (CHUNK_LIM)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_kind_i    (s_axis_tuser),
    .in_size_i    (s_axis_tdata[15:0]),
    .in_addr_i    (s_axis_tdata[35:16]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (res_addr),
    .out_status_o (res_status)
  );

  assign m_axis_tdata = {2'b00, res_status, res_addr};

endmodule

// ===== dv/tb_segregated_pool_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segregated_pool_allocator
// self-checking bench for the power-of-two pool allocator
//
// Allocate and free requests go in on the request stream. A scoreboard keeps
// its own copy of the free lists, links, per-unit class codes and chunk
// count, and predicts each reply when the request transaction is accepted.
// Replies are checked field by field in order. A directed part hits the size
// limits, every class and the odd frees. A random part runs mostly
// alloc/free traffic on live blocks with some noise, then drives the heap
// to exhaustion. Both streams stall at random.
// ----------------------------------------------------------------------------
module tb_segregated_pool_allocator;
  import spa_pkg::*;

  localparam int HEAP_CHUNKS = 256;
  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_ITEMS = 80;

  typedef enum logic {REQ_ALLOC = 1'b0, REQ_FREE = 1'b1} req_kind_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } reply_t;

  class heap_scoreboard;
    logic [LINK_W-1:0] heads [NUM_CLASSES];
    logic [LINK_W-1:0] links [32768];
    logic [CLS_W-1:0]  unit_class [32768];
    int carved;
    int cap;
    int errors;
    reply_t want_q[$];

    function new(int heap_chunks);
      foreach (heads[i]) heads[i] = '0;
      carved = 0;
      errors = 0;
      cap = (heap_chunks < MAX_CHUNKS) ? heap_chunks : MAX_CHUNKS;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function bit can_serve(int c);
      return heads[c][LINK_W-1] || (carved < cap);
    endfunction

    function void carve(int c);
      int base;
      int blk;
      int n;
      int start;
      base = carved * UNITS_PER_CHUNK;
      blk = 1 << c;
      n = UNITS_PER_CHUNK >> c;
      for (int i = 0; i < UNITS_PER_CHUNK; i++) unit_class[base + i] = CLS_W'(c);
      for (int b = 0; b < n; b++) begin
        start = base + b * blk;
        links[start] = (b + 1 < n) ? {1'b1, UNIT_W'(start + blk)} : '0;
      end
      heads[c] = {1'b1, UNIT_W'(base)};
      carved++;
    endfunction

    function reply_t note_request(req_kind_e kind, logic [SIZE_W-1:0] size,
                                  logic [ADDR_W-1:0] payload);
      reply_t r;
      logic [NEED_W-1:0] need;
      logic [UNIT_W-1:0] u;
      logic [ADDR_W-1:0] blk_addr;
      int c;
      r.addr = '0;
      r.status = ST_OK;
      if (kind == REQ_ALLOC) begin
        if (size == '0) begin
          r.status = ST_ZERO;
        end else if (size > POOL_LIMIT) begin
          r.status = ST_BIG;
        end else begin
          need = NEED_W'(size) + HEADER_BYTES;
          c = 0;
          while (c < NUM_CLASSES - 1 && (NEED_W'(32) << c) < need) c++;
          if (!heads[c][LINK_W-1]) begin
            if (carved >= cap) r.status = ST_FULL;
            else carve(c);
          end
          if (r.status == ST_OK) begin
            u = heads[c][UNIT_W-1:0];
            heads[c] = links[u];
            r.addr = {u, 5'd0} + ADDR_W'(8);
          end
        end
      end else if (payload != '0) begin
        blk_addr = payload - ADDR_W'(8);
        u = blk_addr[ADDR_W-1:5];
        if (int'(u) < carved * UNITS_PER_CHUNK) begin
          c = int'(unit_class[u]);
          u = u & ~((UNIT_W'(1) << c) - UNIT_W'(1));
          links[u] = heads[c];
          heads[c] = {1'b1, u};
        end
      end
      want_q.push_back(r);
      return r;
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (want_q.size() == 0) begin
        $error("unexpected result: result_address %h status %0d", got.addr, got.status);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.addr !== want.addr) begin
        $error("result_address mismatch: expected %h, actual %h", want.addr, got.addr);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // request_size[15:0], payload_address[35:16], zero
  logic        s_axis_tuser = 1'b0; // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // result_address[19:0], status[21:20], zero

  bit calm = 1'b0;
  heap_scoreboard sb = new(HEAP_CHUNKS);
  logic [ADDR_W-1:0] live_q[$];
  logic [ADDR_W-1:0] freed_q[$];

  segregated_pool_allocator #(
    .HEAP_CHUNKS(HEAP_CHUNKS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 23);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result({m_axis_tdata[19:0], m_axis_tdata[21:20]});
    end
  end

  task automatic send_request(req_kind_e kind, logic [SIZE_W-1:0] size,
                              logic [ADDR_W-1:0] payload);
    reply_t r;
    while (!calm && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'b0, payload, size};
    do @(posedge clk_i); while (!s_axis_tready);
    r = sb.note_request(kind, size, payload);
    if (kind == REQ_ALLOC && r.status == ST_OK) live_q.push_back(r.addr);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SIZE_W'($urandom_range(1, 248));
    if (r < 85) return SIZE_W'($urandom_range(249, 2040));
    if (r < 93) return SIZE_W'($urandom_range(2041, 4088));
    if (r < 96) return '0;
    return SIZE_W'($urandom_range(4089, 65535));
  endfunction

  task automatic random_item();
    int r;
    int idx;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 50 || (r < 85 && live_q.size() == 0)) begin
      send_request(REQ_ALLOC, rand_size(), ADDR_W'($urandom()));
    end else if (r < 85) begin
      idx = $urandom_range(0, live_q.size() - 1);
      a = live_q[idx];
      live_q.delete(idx);
      freed_q.push_back(a);
      if (freed_q.size() > 16) void'(freed_q.pop_front());
      // interior pointer now and then
      if ($urandom_range(0, 99) < 20) a = a + ADDR_W'($urandom_range(1, 31));
      send_request(REQ_FREE, SIZE_W'($urandom()), a);
    end else if (r < 90 && freed_q.size() != 0) begin
      a = freed_q[$urandom_range(0, freed_q.size() - 1)];
      send_request(REQ_FREE, SIZE_W'($urandom()), a);
    end else if (r < 95) begin
      if ($urandom_range(0, 1)) a = ADDR_W'($urandom_range(0, 20'hFFFFF));
      else a = ADDR_W'($urandom_range(1, sb.carved * CHUNK_BYTES + 64));
      send_request(REQ_FREE, SIZE_W'($urandom()), a);
    end else begin
      send_request(REQ_FREE, SIZE_W'($urandom()), '0);
    end
  endtask

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size limits and at least one allocation per class
    send_request(REQ_ALLOC, 16'd0, 20'hFFFFF);
    send_request(REQ_ALLOC, 16'hFFFF, 20'h0);
    send_request(REQ_ALLOC, 16'd4089, 20'h5A5A5);
    send_request(REQ_ALLOC, 16'd1, 20'hFFFFF);
    send_request(REQ_ALLOC, 16'd24, 20'h0);
    send_request(REQ_ALLOC, 16'd25, 20'h0);
    send_request(REQ_ALLOC, 16'd120, 20'h0);
    send_request(REQ_ALLOC, 16'd248, 20'h0);
    send_request(REQ_ALLOC, 16'd504, 20'h0);
    send_request(REQ_ALLOC, 16'd1016, 20'h0);
    send_request(REQ_ALLOC, 16'd2040, 20'h0);
    send_request(REQ_ALLOC, 16'd2041, 20'h0);
    send_request(REQ_ALLOC, 16'd4088, 20'h0);
    // null, outside the heap, wrap below zero
    send_request(REQ_FREE, 16'hFFFF, 20'h0);
    send_request(REQ_FREE, 16'h0, 20'hFFFFF);
    send_request(REQ_FREE, 16'h0, 20'h00004);
    // plain, double and interior frees
    send_request(REQ_FREE, 16'h0, 20'd8);
    send_request(REQ_FREE, 16'h0, 20'd8);
    send_request(REQ_FREE, 16'h0, 20'd57);
    send_request(REQ_FREE, 16'h0, 20'd4096 + 20'd48);
    send_request(REQ_FREE, 16'h0, 20'd4096 * 11 + 20'd108);
    send_request(REQ_ALLOC, 16'd1, 20'h0);
    send_request(REQ_ALLOC, 16'd1, 20'h0);
    send_request(REQ_ALLOC, 16'd1, 20'h0);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 400 && i < 550);
      if (i == 600) drain();
      random_item();
    end

    // use up the heap with largest blocks, then hit the exhausted case
    // a double free can loop a list, so the walk is bounded
    for (int n = 0; n < HEAP_CHUNKS + 64 && sb.can_serve(NUM_CLASSES - 1); n++) begin
      send_request(REQ_ALLOC, SIZE_W'($urandom_range(2041, 4088)), ADDR_W'($urandom()));
    end
    send_request(REQ_ALLOC, 16'd4088, 20'h0);
    for (int i = 0; i < TAIL_ITEMS; i++) random_item();

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spa_pkg.sv
hw/rtl/spa_ram.sv
hw/rtl/spa_ctrl.sv
hw/rtl/spa_datapath.sv
hw/rtl/segregated_pool_allocator.sv
dv/tb_segregated_pool_allocator.sv
